FILE: src/bt2c_pkg.sv
// Package for the bipartite two-coloring block.
// Holds request and result transaction types, request and status codes,
// color codes and default sizes. Depends on nothing.
`default_nettype none

package bt2c_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int DEF_MAX_VERTICES = 1024;
	localparam int DEF_MAX_EDGES    = 4096;

	// Vertex count register.
	localparam int               VERTEX_COUNT_W     = 11;
	localparam logic [10:0]      VERTEX_COUNT_RESET = 11'd1024;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_SOLVE = 2'd1,
		REQ_READ  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_code_t;

	// Status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_NOT_BIP = 2'd3
	} status_t;

	// Color codes.
	localparam logic [1:0] COLOR_NONE = 2'd0;
	localparam logic [1:0] COLOR_ONE  = 2'd1;
	localparam logic [1:0] COLOR_TWO  = 2'd2;

	// Request transaction.
	typedef struct packed {
		req_code_t   req_type;
		logic [9:0]  end_a;
		logic [9:0]  end_b;
	} req_t;

	// Result transaction.
	typedef struct packed {
		status_t     status;
		logic        is_bipartite;
		logic [1:0]  vertex_color;
		logic [10:0] first_color_total;
		logic [10:0] second_color_total;
	} rsp_t;

endpackage

`default_nettype wire

FILE: src/bt2c_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
`default_nettype none

module bt2c_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/bt2c_ctrl.sv
// Request sequencer for the two-coloring block: edge loads, color reads,
// clears and the solve walk over the edge, color and stack memories.
// Depends on bt2c_pkg; the memories themselves sit in the top level.
`default_nettype none

module bt2c_ctrl
	import bt2c_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES,
	localparam int VW  = $clog2(MAX_VERTICES),
	localparam int NW  = $clog2(MAX_VERTICES + 1),
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int ETW = $clog2(MAX_EDGES + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire req_t            in_data,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output rsp_t                 out_data,
	input  wire logic [NW-1:0]   n,
	// Edge memory.
	output logic                 e_we,
	output logic [EAW-1:0]       e_waddr,
	output logic [2*VW-1:0]      e_wdata,
	output logic [EAW-1:0]       e_raddr,
	input  wire logic [2*VW-1:0] e_rdata,
	// Color memory.
	output logic                 c_we,
	output logic [VW-1:0]        c_waddr,
	output logic [1:0]           c_wdata,
	output logic [VW-1:0]        c_raddr,
	input  wire logic [1:0]      c_rdata,
	// Work stack memory.
	output logic                 s_we,
	output logic [VW-1:0]        s_waddr,
	output logic [VW-1:0]        s_wdata,
	output logic [VW-1:0]        s_raddr,
	input  wire logic [VW-1:0]   s_rdata
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_FIN   = 14'b00000000000010,
		S_RDW   = 14'b00000000000100,
		S_CLR   = 14'b00000000001000,
		S_SCAN  = 14'b00000000010000,
		S_SCANW = 14'b00000000100000,
		S_POP   = 14'b00000001000000,
		S_POPW  = 14'b00000010000000,
		S_VCOL  = 14'b00000100000000,
		S_EDGE  = 14'b00001000000000,
		S_EDGW  = 14'b00010000000000,
		S_UCOL  = 14'b00100000000000,
		S_SPARE = 14'b01000000000000,
		S_HOLD  = 14'b10000000000000
	} state_t;

	state_t          state_q;
	logic [ETW-1:0]  edge_total_q;
	logic            solved_q;
	logic [NW-1:0]   tot1_q;
	logic [NW-1:0]   tot2_q;
	logic [NW-1:0]   c1_q;
	logic [NW-1:0]   c2_q;
	logic [VW-1:0]   ci_q;
	logic [NW-1:0]   si_q;
	logic [NW-1:0]   depth_q;
	logic [VW-1:0]   v_q;
	logic [VW-1:0]   u_q;
	logic [1:0]      other_q;
	logic [ETW-1:0]  e_q;
	logic            rd_in_q;
	rsp_t            res_q;
	rsp_t            out_q;
	logic            out_valid_q;

	logic            load_out;
	logic            take;
	logic            add_a_in;
	logic            add_b_in;
	logic [VW-1:0]   ea;
	logic [VW-1:0]   eb;
	logic            edge_hit;
	logic [VW-1:0]   edge_u;

	// True when a vertex number lies below the active vertex count.
	function automatic logic in_range(input logic [31:0] x, input logic [NW-1:0] cnt);
		return x < 32'(cnt);
	endfunction

	// Builds one result transaction.
	function automatic rsp_t mk_rsp(input status_t st, input logic [1:0] col,
			input logic ok, input logic [NW-1:0] t1, input logic [NW-1:0] t2);
		rsp_t r;
		r.status             = st;
		r.is_bipartite       = ok;
		r.vertex_color       = col;
		r.first_color_total  = 11'(t1);
		r.second_color_total = 11'(t2);
		return r;
	endfunction

	// Handshake: a finished result moves to the output register when it is free.
	assign load_out  = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign in_stall  = !((state_q == S_IDLE) || load_out);
	assign take      = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign add_a_in = in_range(32'(in_data.end_a), n);
	assign add_b_in = in_range(32'(in_data.end_b), n);

	// Decode of the edge just read: which endpoint is the neighbor of v.
	always_comb begin
		ea       = e_rdata[2*VW-1:VW];
		eb       = e_rdata[VW-1:0];
		edge_hit = 1'b0;
		edge_u   = eb;
		if (in_range(32'(ea), n) && in_range(32'(eb), n)) begin
			if (ea == v_q) begin
				edge_hit = 1'b1;
				edge_u   = eb;
			end else if (eb == v_q) begin
				edge_hit = 1'b1;
				edge_u   = ea;
			end
		end
	end

	// Memory port control.
	always_comb begin
		e_we    = 1'b0;
		e_waddr = EAW'(edge_total_q);
		e_wdata = {VW'(in_data.end_a), VW'(in_data.end_b)};
		e_raddr = EAW'(e_q);
		c_we    = 1'b0;
		c_waddr = VW'(si_q);
		c_wdata = COLOR_NONE;
		c_raddr = VW'(si_q);
		s_we    = 1'b0;
		s_waddr = VW'(depth_q);
		s_wdata = u_q;
		s_raddr = VW'(depth_q - NW'(1));
		if (take) begin
			if (in_data.req_type == REQ_ADD && add_a_in && add_b_in
					&& edge_total_q != ETW'(MAX_EDGES)) begin
				e_we = 1'b1;
			end
			c_raddr = VW'(in_data.end_a);
		end else begin
			unique case (state_q)
				S_CLR: begin
					c_we    = 1'b1;
					c_waddr = ci_q;
					c_wdata = COLOR_NONE;
				end
				S_SCANW: begin
					if (c_rdata == COLOR_NONE) begin
						c_we    = 1'b1;
						c_waddr = VW'(si_q);
						c_wdata = COLOR_ONE;
						s_we    = 1'b1;
						s_waddr = '0;
						s_wdata = VW'(si_q);
					end
				end
				S_POPW:  c_raddr = s_rdata;
				S_EDGW:  c_raddr = edge_u;
				S_UCOL: begin
					if (c_rdata == COLOR_NONE) begin
						c_we    = 1'b1;
						c_waddr = u_q;
						c_wdata = other_q;
						s_we    = 1'b1;
						s_waddr = VW'(depth_q);
						s_wdata = u_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			edge_total_q <= '0;
			solved_q     <= 1'b0;
			tot1_q       <= '0;
			tot2_q       <= '0;
			c1_q         <= '0;
			c2_q         <= '0;
			ci_q         <= '0;
			si_q         <= '0;
			depth_q      <= '0;
			v_q          <= '0;
			u_q          <= '0;
			other_q      <= COLOR_ONE;
			e_q          <= '0;
			rd_in_q      <= 1'b0;
			res_q        <= '0;
		end else if (take) begin
			unique case (in_data.req_type)
				REQ_ADD: begin
					if (!(add_a_in && add_b_in)) begin
						res_q <= mk_rsp(ST_RANGE, COLOR_NONE, solved_q, tot1_q, tot2_q);
					end else if (edge_total_q == ETW'(MAX_EDGES)) begin
						res_q <= mk_rsp(ST_FULL, COLOR_NONE, solved_q, tot1_q, tot2_q);
					end else begin
						edge_total_q <= edge_total_q + ETW'(1);
						res_q <= mk_rsp(ST_OK, COLOR_NONE, solved_q, tot1_q, tot2_q);
					end
					state_q <= S_FIN;
				end
				REQ_SOLVE: begin
					ci_q    <= '0;
					c1_q    <= '0;
					c2_q    <= '0;
					state_q <= S_CLR;
				end
				REQ_READ: begin
					rd_in_q <= add_a_in;
					state_q <= S_RDW;
				end
				REQ_CLEAR: begin
					edge_total_q <= '0;
					solved_q     <= 1'b0;
					tot1_q       <= '0;
					tot2_q       <= '0;
					res_q        <= mk_rsp(ST_OK, COLOR_NONE, 1'b0, '0, '0);
					state_q      <= S_FIN;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (state_q)
				S_FIN: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				// Color read result.
				S_RDW: begin
					res_q <= mk_rsp(rd_in_q ? ST_OK : ST_RANGE,
						(rd_in_q && solved_q) ? c_rdata : COLOR_NONE,
						solved_q, tot1_q, tot2_q);
					state_q <= S_FIN;
				end
				// Wipe every color entry before the walk.
				S_CLR: begin
					ci_q <= ci_q + VW'(1);
					if (ci_q == VW'(MAX_VERTICES - 1)) begin
						si_q    <= '0;
						state_q <= S_SCAN;
					end
				end
				// Look for the next uncolored seed vertex.
				S_SCAN: begin
					if (si_q == n) begin
						solved_q <= 1'b1;
						tot1_q   <= c1_q;
						tot2_q   <= c2_q;
						res_q    <= mk_rsp(ST_OK, COLOR_NONE, 1'b1, c1_q, c2_q);
						state_q  <= S_FIN;
					end else begin
						state_q <= S_SCANW;
					end
				end
				S_SCANW: begin
					if (c_rdata == COLOR_NONE) begin
						c1_q    <= c1_q + NW'(1);
						depth_q <= NW'(1);
						state_q <= S_POP;
					end else begin
						si_q    <= si_q + NW'(1);
						state_q <= S_SCAN;
					end
				end
				// Pop the next vertex of the component.
				S_POP: begin
					if (depth_q == '0) begin
						si_q    <= si_q + NW'(1);
						state_q <= S_SCAN;
					end else begin
						depth_q <= depth_q - NW'(1);
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					v_q     <= s_rdata;
					state_q <= S_VCOL;
				end
				S_VCOL: begin
					other_q <= (c_rdata == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;
					e_q     <= '0;
					state_q <= S_EDGE;
				end
				// Walk the stored edges for neighbors of v.
				S_EDGE: begin
					state_q <= (e_q == edge_total_q) ? S_POP : S_EDGW;
				end
				S_EDGW: begin
					if (edge_hit) begin
						u_q     <= edge_u;
						state_q <= S_UCOL;
					end else begin
						e_q     <= e_q + ETW'(1);
						state_q <= S_EDGE;
					end
				end
				// Color the neighbor, or detect a conflict.
				S_UCOL: begin
					if (c_rdata == COLOR_NONE) begin
						if (other_q == COLOR_ONE) begin
							c1_q <= c1_q + NW'(1);
						end else begin
							c2_q <= c2_q + NW'(1);
						end
						depth_q <= depth_q + NW'(1);
						e_q     <= e_q + ETW'(1);
						state_q <= S_EDGE;
					end else if (c_rdata != other_q) begin
						solved_q <= 1'b0;
						tot1_q   <= '0;
						tot2_q   <= '0;
						res_q    <= mk_rsp(ST_NOT_BIP, COLOR_NONE, 1'b0, '0, '0);
						state_q  <= S_FIN;
					end else begin
						e_q     <= e_q + ETW'(1);
						state_q <= S_EDGE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			out_q       <= res_q;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: src/bipartite_two_coloring.sv
// Bipartite check by two-coloring. Edges are loaded one per transaction into
// an edge memory; a solve wipes the color memory, then scans vertices in order
// and walks every component through a work stack, reading all stored edges
// for each popped vertex to find its neighbors. An add-edge or clear
// transaction places its result in a result register, from which it moves to
// the output register once that is free; the next transaction can be taken in
// that same cycle. A color read first waits for the registered color-memory
// read. The solve time is set by the single edge-memory read port. A result
// can wait in the output register while the next transaction is taken.
// Depends on bt2c_pkg, bt2c_ram and bt2c_ctrl.
`default_nettype none

module bipartite_two_coloring
	import bt2c_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire req_t                      in_data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output rsp_t                           out_data,
	input  wire logic                      cfg_write_en,
	input  wire logic [VERTEX_COUNT_W-1:0] cfg_write_data
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int NW  = $clog2(MAX_VERTICES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	logic [VERTEX_COUNT_W-1:0] vcount_q;
	logic [NW-1:0]             n_used;

	logic            e_we;
	logic [EAW-1:0]  e_waddr;
	logic [2*VW-1:0] e_wdata;
	logic [EAW-1:0]  e_raddr;
	logic [2*VW-1:0] e_rdata;
	logic            c_we;
	logic [VW-1:0]   c_waddr;
	logic [1:0]      c_wdata;
	logic [VW-1:0]   c_raddr;
	logic [1:0]      c_rdata;
	logic            s_we;
	logic [VW-1:0]   s_waddr;
	logic [VW-1:0]   s_wdata;
	logic [VW-1:0]   s_raddr;
	logic [VW-1:0]   s_rdata;

	// Vertex count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VERTEX_COUNT_RESET;
		end else if (cfg_write_en) begin
			vcount_q <= cfg_write_data;
		end
	end

	// Clamp the vertex count to 1..MAX_VERTICES.
	always_comb begin
		if (vcount_q == '0) begin
			n_used = NW'(1);
		end else if (32'(vcount_q) > 32'(MAX_VERTICES)) begin
			n_used = NW'(MAX_VERTICES);
		end else begin
			n_used = NW'(vcount_q);
		end
	end

	bt2c_ctrl #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.n         (n_used),
		.e_we      (e_we),
		.e_waddr   (e_waddr),
		.e_wdata   (e_wdata),
		.e_raddr   (e_raddr),
		.e_rdata   (e_rdata),
		.c_we      (c_we),
		.c_waddr   (c_waddr),
		.c_wdata   (c_wdata),
		.c_raddr   (c_raddr),
		.c_rdata   (c_rdata),
		.s_we      (s_we),
		.s_waddr   (s_waddr),
		.s_wdata   (s_wdata),
		.s_raddr   (s_raddr),
		.s_rdata   (s_rdata)
	);

	// Edge memory: both endpoints of one edge per entry.
	bt2c_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_mem (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	// Color memory: one two-bit color per vertex.
	bt2c_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES), .AW(VW)) u_color_mem (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// Work stack memory for the component walk.
	bt2c_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES), .AW(VW)) u_stack_mem (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

endmodule

`default_nettype wire
